// ===== sv/owst_pkg.sv =====
package owst_pkg;

    localparam int TIMER_BITS_DEF = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W1_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_SAMPLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_TAIL    = 3'd6;

    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_RST_LOW  = 8'b0000_0010,
        PH_RST_WAIT = 8'b0000_0100,
        PH_W_LOW    = 8'b0000_1000,
        PH_W_HIGH   = 8'b0001_0000,
        PH_R_LOW    = 8'b0010_0000,
        PH_R_SAMPLE = 8'b0100_0000,
        PH_R_TAIL   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [9:0] reset_wait_ticks;
        logic [7:0] slot_ticks;
        logic [3:0] write_one_low_ticks;
        logic [3:0] read_low_ticks;
        logic [5:0] read_sample_ticks;
        logic [7:0] read_tail_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] command;
        logic [2:0] bit_index;
        logic [7:0] shift_byte;
    } seq_t;

endpackage

// ===== sv/owst_if.sv =====
interface owst_cmd_if;
    logic       valid;
    logic       ready;
    logic       tick;
    logic       start_req;
    logic [1:0] operation;
    logic [7:0] write_byte;
    logic       line_level;

    modport source (output valid, tick, start_req, operation, write_byte, line_level,
                    input ready);
    modport sink (input valid, tick, start_req, operation, write_byte, line_level,
                  output ready);
endinterface

interface owst_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;

    modport source (output valid, drive_low, busy_res, done_res, read_byte, input ready);
    modport sink (input valid, drive_low, busy_res, done_res, read_byte, output ready);
endinterface

interface owst_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/owst_cfg_regs.sv =====
module owst_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    owst_cfg_if.sink      cfg,
    output owst_pkg::cfg_t regs
);
    import owst_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RESET_LOW:  regs_next.reset_low_ticks     = cfg.data;
                CFG_RESET_WAIT: regs_next.reset_wait_ticks    = cfg.data;
                CFG_SLOT:       regs_next.slot_ticks          = cfg.data[7:0];
                CFG_W1_LOW:     regs_next.write_one_low_ticks = cfg.data[3:0];
                CFG_RD_LOW:     regs_next.read_low_ticks      = cfg.data[3:0];
                CFG_RD_SAMPLE:  regs_next.read_sample_ticks   = cfg.data[5:0];
                CFG_RD_TAIL:    regs_next.read_tail_ticks     = cfg.data[7:0];
                default:        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.reset_low_ticks     <= 10'd480;
            regs_reg.reset_wait_ticks    <= 10'd480;
            regs_reg.slot_ticks          <= 8'd60;
            regs_reg.write_one_low_ticks <= 4'd1;
            regs_reg.read_low_ticks      <= 4'd2;
            regs_reg.read_sample_ticks   <= 6'd10;
            regs_reg.read_tail_ticks     <= 8'd50;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end
endmodule

// ===== sv/owst_step.sv =====
module owst_step #(
    parameter int TIMER_BITS = owst_pkg::TIMER_BITS_DEF
) (
    input  owst_pkg::seq_t       seq,
    input  logic [TIMER_BITS-1:0] timer,
    input  owst_pkg::cfg_t       regs,
    input  logic                 tick,
    input  logic                 start_req,
    input  logic [1:0]           operation,
    input  logic [7:0]           write_byte,
    input  logic                 line_level,
    output owst_pkg::seq_t       seq_next,
    output logic [TIMER_BITS-1:0] timer_next,
    output logic                 done
);
    import owst_pkg::*;

    localparam int CW = ((TIMER_BITS > 10) ? TIMER_BITS : 10) + 1;
    localparam logic [CW-1:0] TMAX = CW'((1 << TIMER_BITS) - 1);

    logic [9:0]    len_raw;
    logic [CW-1:0] len_ext;
    logic [CW-1:0] len_clip;
    logic [CW-1:0] timer_inc;
    logic          bit0;

    assign bit0 = seq.shift_byte[0];

    always_comb
    begin
        unique case (seq.phase)
            PH_RST_LOW:  len_raw = regs.reset_low_ticks;
            PH_RST_WAIT: len_raw = regs.reset_wait_ticks;
            PH_W_LOW:    len_raw = bit0 ? 10'(regs.write_one_low_ticks)
                                        : 10'(regs.slot_ticks);
            PH_W_HIGH:   len_raw = bit0 ? 10'(regs.slot_ticks) : 10'd1;
            PH_R_LOW:    len_raw = 10'(regs.read_low_ticks);
            PH_R_SAMPLE: len_raw = 10'(regs.read_sample_ticks);
            PH_R_TAIL:   len_raw = 10'(regs.read_tail_ticks);
            default:     len_raw = 10'd1;
        endcase
    end

    assign len_ext   = CW'(len_raw);
    assign len_clip  = (len_ext > TMAX) ? TMAX : len_ext;
    assign timer_inc = CW'(timer) + CW'(1);

    always_comb
    begin
        seq_next   = seq;
        timer_next = timer;
        done       = 1'b0;
        if (seq.phase == PH_IDLE)
        begin
            if (start_req && operation != OP_NONE)
            begin
                seq_next.command    = operation;
                seq_next.bit_index  = 3'd0;
                timer_next          = '0;
                seq_next.shift_byte = (operation == OP_WRITE) ? write_byte : 8'd0;
                unique case (operation)
                    OP_RESET: seq_next.phase = PH_RST_LOW;
                    OP_WRITE: seq_next.phase = PH_W_LOW;
                    default:  seq_next.phase = PH_R_LOW;
                endcase
            end
        end
        else if (tick)
        begin
            if (timer_inc >= len_clip)
            begin
                timer_next = '0;
                unique case (seq.phase)
                    PH_RST_LOW:  seq_next.phase = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        seq_next.phase = PH_IDLE;
                        done           = 1'b1;
                    end
                    PH_W_LOW:    seq_next.phase = PH_W_HIGH;
                    PH_W_HIGH:
                    begin
                        if (seq.bit_index == 3'd7)
                        begin
                            seq_next.phase = PH_IDLE;
                            done           = 1'b1;
                        end
                        else
                        begin
                            seq_next.bit_index  = seq.bit_index + 3'd1;
                            seq_next.shift_byte = {1'b0, seq.shift_byte[7:1]};
                            seq_next.phase      = PH_W_LOW;
                        end
                    end
                    PH_R_LOW:    seq_next.phase = PH_R_SAMPLE;
                    PH_R_SAMPLE:
                    begin
                        seq_next.shift_byte = {line_level, seq.shift_byte[7:1]};
                        seq_next.phase      = PH_R_TAIL;
                    end
                    PH_R_TAIL:
                    begin
                        if (seq.bit_index == 3'd7)
                        begin
                            seq_next.phase = PH_IDLE;
                            done           = 1'b1;
                        end
                        else
                        begin
                            seq_next.bit_index = seq.bit_index + 3'd1;
                            seq_next.phase     = PH_R_LOW;
                        end
                    end
                    default:     seq_next.phase = PH_IDLE;
                endcase
            end
            else
            begin
                timer_next = timer_inc[TIMER_BITS-1:0];
            end
        end
    end
endmodule

// ===== sv/onewire_master_slot_timer.sv =====
// channel | dir | signals                                              | accepted when
// cmd     | in  | tick start_req operation write_byte line_level       | valid && ready
// res     | out | drive_low busy_res done_res read_byte                | valid && ready
// cfg     | in  | index data (ready tied high)                         | valid && ready
//
// One item per cycle while cmd.ready is high: each accepted cmd item updates the phase
// sequencer and loads the result register in the same edge; its result shows next cycle.
// cmd.ready drops only while the result register holds an item that res does not take.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and the config to defaults.
// Phase timers advance only on accepted items with tick set.
module onewire_master_slot_timer #(
    parameter int TIMER_BITS = owst_pkg::TIMER_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    owst_cmd_if.sink  cmd,
    owst_res_if.source res,
    owst_cfg_if.sink  cfg
);
    import owst_pkg::*;

    cfg_t                  regs;
    seq_t                  seq_reg;
    seq_t                  seq_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic                  done;
    logic                  accept;

    logic                  valid_reg;
    logic                  drive_low_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [7:0]            read_byte_reg;

    owst_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    owst_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .seq        (seq_reg),
        .timer      (timer_reg),
        .regs       (regs),
        .tick       (cmd.tick),
        .start_req  (cmd.start_req),
        .operation  (cmd.operation),
        .write_byte (cmd.write_byte),
        .line_level (cmd.line_level),
        .seq_next   (seq_next),
        .timer_next (timer_next),
        .done       (done)
    );

    assign cmd.ready = !valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg.phase      <= PH_IDLE;
            seq_reg.command    <= 2'd0;
            seq_reg.bit_index  <= 3'd0;
            seq_reg.shift_byte <= 8'd0;
            timer_reg          <= '0;
            valid_reg          <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                seq_reg   <= seq_next;
                timer_reg <= timer_next;
                valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_low_reg <= (seq_next.phase == PH_RST_LOW) || (seq_next.phase == PH_W_LOW)
                             || (seq_next.phase == PH_R_LOW);
            busy_reg      <= (seq_next.phase != PH_IDLE);
            done_reg      <= done;
            read_byte_reg <= (seq_next.phase == PH_IDLE && seq_next.command == OP_READ)
                             ? seq_next.shift_byte : 8'd0;
        end
    end

    assign res.valid     = valid_reg;
    assign res.drive_low = drive_low_reg;
    assign res.busy_res  = busy_reg;
    assign res.done_res  = done_reg;
    assign res.read_byte = read_byte_reg;
endmodule
